>>> rtl/disk_request_queue_picker_macros.svh
// Assertion macros shared by the disk request queue checker.
`ifndef DISK_REQUEST_QUEUE_PICKER_MACROS_SVH
`define DISK_REQUEST_QUEUE_PICKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRQP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRQP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/drqp_pkg.sv
// Types and constants of the disk request queue picker.
package drqp_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W = 5;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] KIND_READ       = 2'd0;
	localparam logic [1:0] KIND_WRITE      = 2'd1;
	localparam logic [1:0] KIND_SYNC       = 2'd2;
	localparam logic [1:0] KIND_SYNC_WRITE = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  req_kind;
		logic [31:0] sector_num;
		logic [15:0] requester_id;
		logic [15:0] buffer_handle;
	} item_t;

	typedef struct packed {
		logic             accepted;
		logic             queue_full;
		logic [1:0]       out_kind;
		logic [31:0]      out_sector;
		logic [15:0]      out_requester;
		logic [15:0]      out_handle;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] sector;
		logic [15:0] requester;
		logic [15:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/drqp_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module drqp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/disk_request_queue_picker.sv
// Disk request queue picker: a request queue in RAM with a sync, read-after-write pick policy.
//
// A transaction is accepted when start is high and busy is low; its result shows on result for
// exactly one cycle with done high, and the receiver cannot stall it. A push, and a pop on an
// empty queue, are answered in the cycle after acceptance. A pop on a queue of n entries walks
// the single-port-read entry RAM: one pass over all entries looking for the newest sync entry,
// the newest read and the oldest entry, a second pass comparing sectors against the newest
// read when that read decides the pick, then a compaction that moves every newer entry down
// one slot. A pop thus keeps busy high while these passes run through the one read port of
// the entry RAM and the single sector comparator, and its result shows in the first cycle
// with busy low again.
module disk_request_queue_picker
	import drqp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN1 = 4'b0010,
		ST_SCAN2 = 4'b0100,
		ST_SHIFT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   rd_q;
	logic               pend_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic               sync_hit_q;
	logic               read_hit_q;
	logic               wr_hit_q;
	logic [IDX_W-1:0]   sync_slot_q;
	logic [IDX_W-1:0]   read_slot_q;
	logic [IDX_W-1:0]   wr_slot_q;
	entry_t             sync_ent_q;
	entry_t             read_ent_q;
	entry_t             wr_ent_q;
	entry_t             old_ent_q;
	entry_t             pick_ent_q;
	result_t            result_q;
	logic               done_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rent;
	entry_t             push_ent;
	logic               scan_end;
	logic [IDX_W-1:0]   pick_slot_d;
	entry_t             pick_ent_d;
	logic               is_sync;
	logic               is_read;
	logic               is_wr_match;
	logic               full;

	drqp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rent     = entry_t'(ram_rdata);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign scan_end = (cnt_q == '0) && !pend_q;

	assign push_ent.kind      = item.req_kind;
	assign push_ent.sector    = item.sector_num;
	assign push_ent.requester = item.requester_id;
	assign push_ent.handle    = item.buffer_handle;

	// The single sector comparator serves the second pass only.
	assign is_sync     = (rent.kind == KIND_SYNC) || (rent.kind == KIND_SYNC_WRITE);
	assign is_read     = (rent.kind == KIND_READ);
	assign is_wr_match = (rent.kind == KIND_WRITE) && (rent.sector == read_ent_q.sector);

	always_comb begin
		if (state_q == ST_SHIFT) begin
			ram_raddr = rd_q;
		end else begin
			ram_raddr = IDX_W'(cnt_q - CNT_W'(1));
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(count_q);
		ram_wdata = push_ent;
		if (state_q == ST_IDLE) begin
			ram_we = start && (item.cmd == CMD_PUSH) && !full;
		end else if (state_q == ST_SHIFT) begin
			ram_we    = pend_q;
			ram_waddr = pend_idx_q - IDX_W'(1);
			ram_wdata = ram_rdata;
		end
	end

	always_comb begin
		if (state_q == ST_SCAN1) begin
			if (sync_hit_q) begin
				pick_slot_d = sync_slot_q;
				pick_ent_d  = sync_ent_q;
			end else begin
				pick_slot_d = '0;
				pick_ent_d  = old_ent_q;
			end
		end else if (wr_hit_q) begin
			pick_slot_d = wr_slot_q;
			pick_ent_d  = wr_ent_q;
		end else begin
			pick_slot_d = read_slot_q;
			pick_ent_d  = read_ent_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cnt_q       <= '0;
			rd_q        <= '0;
			pend_q      <= 1'b0;
			pend_idx_q  <= '0;
			sync_hit_q  <= 1'b0;
			read_hit_q  <= 1'b0;
			wr_hit_q    <= 1'b0;
			sync_slot_q <= '0;
			read_slot_q <= '0;
			wr_slot_q   <= '0;
			result_q    <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q != ST_IDLE) begin
				pend_q     <= (cnt_q != '0);
				pend_idx_q <= ram_raddr;
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (item.cmd == CMD_PUSH) begin
							result_q <= '0;
							done_q   <= 1'b1;
							if (full) begin
								result_q.queue_full <= 1'b1;
								result_q.occupancy  <= OCC_W'(count_q);
							end else begin
								result_q.accepted  <= 1'b1;
								result_q.occupancy <= OCC_W'(CNT_W'(count_q + CNT_W'(1)));
								count_q            <= count_q + CNT_W'(1);
							end
						end else if (count_q == '0) begin
							result_q <= '0;
							done_q   <= 1'b1;
						end else begin
							state_q    <= ST_SCAN1;
							cnt_q      <= count_q;
							pend_q     <= 1'b0;
							sync_hit_q <= 1'b0;
							read_hit_q <= 1'b0;
							wr_hit_q   <= 1'b0;
						end
					end
				end
				ST_SCAN1: begin
					if (pend_q) begin
						if (is_sync && !sync_hit_q) begin
							sync_hit_q  <= 1'b1;
							sync_slot_q <= pend_idx_q;
						end
						if (is_read && !read_hit_q) begin
							read_hit_q  <= 1'b1;
							read_slot_q <= pend_idx_q;
						end
					end
					if (scan_end) begin
						if (sync_hit_q || !read_hit_q) begin
							state_q <= ST_SHIFT;
							rd_q    <= pick_slot_d + IDX_W'(1);
							cnt_q   <= count_q - CNT_W'(1) - CNT_W'(pick_slot_d);
						end else begin
							state_q <= ST_SCAN2;
							cnt_q   <= count_q;
						end
					end
				end
				ST_SCAN2: begin
					if (pend_q && is_wr_match && !wr_hit_q) begin
						wr_hit_q  <= 1'b1;
						wr_slot_q <= pend_idx_q;
					end
					if (scan_end) begin
						state_q <= ST_SHIFT;
						rd_q    <= pick_slot_d + IDX_W'(1);
						cnt_q   <= count_q - CNT_W'(1) - CNT_W'(pick_slot_d);
					end
				end
				ST_SHIFT: begin
					if (cnt_q != '0) begin
						rd_q <= rd_q + IDX_W'(1);
					end
					if (scan_end) begin
						state_q                <= ST_IDLE;
						count_q                <= count_q - CNT_W'(1);
						done_q                 <= 1'b1;
						result_q.accepted      <= 1'b1;
						result_q.queue_full    <= 1'b0;
						result_q.out_kind      <= pick_ent_q.kind;
						result_q.out_sector    <= pick_ent_q.sector;
						result_q.out_requester <= pick_ent_q.requester;
						result_q.out_handle    <= pick_ent_q.handle;
						result_q.occupancy     <= OCC_W'(CNT_W'(count_q - CNT_W'(1)));
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Entry captures taken while the scan passes stream the RAM.
	always_ff @(posedge clk) begin
		if (pend_q && (state_q == ST_SCAN1)) begin
			if (is_sync && !sync_hit_q) begin
				sync_ent_q <= rent;
			end
			if (is_read && !read_hit_q) begin
				read_ent_q <= rent;
			end
			if (pend_idx_q == '0) begin
				old_ent_q <= rent;
			end
		end
		if (pend_q && (state_q == ST_SCAN2) && is_wr_match && !wr_hit_q) begin
			wr_ent_q <= rent;
		end
		if (scan_end && ((state_q == ST_SCAN1) || (state_q == ST_SCAN2))) begin
			pick_ent_q <= pick_ent_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/drqp_checker.sv
// Port-level assertions for the disk request queue picker, with the bind that attaches them.
`include "disk_request_queue_picker_macros.svh"

module drqp_checker
	import drqp_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input item_t   item,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// A result is only delivered once the sequencer has returned to idle.
	`DRQP_ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !busy, "result strobed while busy")

	// A push transaction is always answered in the following cycle.
	`DRQP_ASSERT_NXT(a_push_answered, clk, arst_n, start && !busy && (item.cmd == CMD_PUSH), done, "push transaction not answered next cycle")

	// A result never reports both success and a refused push.
	`DRQP_ASSERT_IMP(a_flags_excl, clk, arst_n, done, !(result.accepted && result.queue_full), "accepted and queue_full both set")

	// A refused push reports a full queue and no popped request.
	`DRQP_ASSERT_IMP(a_full_occ, clk, arst_n, done && result.queue_full, (result.occupancy == OCC_W'(QUEUE_DEPTH)) && (result.out_sector == '0), "queue_full with wrong occupancy or payload")

endmodule

bind disk_request_queue_picker drqp_checker u_drqp_checker (.*);
